/* rtl/assert_macros.svh */
// Assertion helpers used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, ignored while in reset
`define AST_IMPL(lbl, ante, cons) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (ante) |-> (cons)) else $error("implication check failed");
// next-cycle implication, ignored while in reset
`define AST_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (ante) |=> (cons)) else $error("next-cycle check failed");
// condition that must hold right after a reset cycle
`define AST_RST(lbl, cons) lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
  else $error("reset check failed");
`endif

/* rtl/prvm_pkg.sv */
package prvm_pkg;

  localparam int TRIG_STEPS = 512;
  localparam int ROT_W      = $clog2(TRIG_STEPS);
  localparam int COORD_W    = 16;
  localparam int ANGLE_W    = 10;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUO_W      = 17;

  // opcodes
  localparam logic [OP_W-1:0] OP_MAP    = 2'd0;
  localparam logic [OP_W-1:0] OP_UNMAP  = 2'd1;
  localparam logic [OP_W-1:0] OP_ROTATE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROTATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd4;

  // Q15 quarter-wave sine, 129 points
  localparam logic [15:0] QSIN [0:128] = '{
    16'd0, 16'd402, 16'd804, 16'd1206, 16'd1607, 16'd2009, 16'd2410, 16'd2811,
    16'd3211, 16'd3611, 16'd4011, 16'd4409, 16'd4807, 16'd5205, 16'd5601, 16'd5997,
    16'd6392, 16'd6786, 16'd7179, 16'd7571, 16'd7961, 16'd8351, 16'd8739, 16'd9126,
    16'd9511, 16'd9895, 16'd10278, 16'd10659, 16'd11038, 16'd11416, 16'd11792,
    16'd12166, 16'd12539, 16'd12909, 16'd13278, 16'd13645, 16'd14009, 16'd14372,
    16'd14732, 16'd15090, 16'd15446, 16'd15799, 16'd16150, 16'd16499, 16'd16845,
    16'd17189, 16'd17530, 16'd17868, 16'd18204, 16'd18537, 16'd18867, 16'd19194,
    16'd19519, 16'd19840, 16'd20159, 16'd20474, 16'd20787, 16'd21096, 16'd21402,
    16'd21705, 16'd22004, 16'd22301, 16'd22594, 16'd22883, 16'd23169, 16'd23452,
    16'd23731, 16'd24006, 16'd24278, 16'd24546, 16'd24811, 16'd25072, 16'd25329,
    16'd25582, 16'd25831, 16'd26077, 16'd26318, 16'd26556, 16'd26789, 16'd27019,
    16'd27244, 16'd27466, 16'd27683, 16'd27896, 16'd28105, 16'd28309, 16'd28510,
    16'd28706, 16'd28897, 16'd29085, 16'd29268, 16'd29446, 16'd29621, 16'd29790,
    16'd29955, 16'd30116, 16'd30272, 16'd30424, 16'd30571, 16'd30713, 16'd30851,
    16'd30984, 16'd31113, 16'd31236, 16'd31356, 16'd31470, 16'd31580, 16'd31684,
    16'd31785, 16'd31880, 16'd31970, 16'd32056, 16'd32137, 16'd32213, 16'd32284,
    16'd32350, 16'd32412, 16'd32468, 16'd32520, 16'd32567, 16'd32609, 16'd32646,
    16'd32678, 16'd32705, 16'd32727, 16'd32744, 16'd32757, 16'd32764, 16'd32767
  };

  // item fields carried alongside the divider
  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [ROT_W-1:0]          rot;
  } prvm_side_t;

  // one divider lane: sign, too-large flag, partial remainder, divisor, quotient
  typedef struct packed {
    logic             neg;
    logic             big;
    logic [31:0]      rem;
    logic [15:0]      dvs;
    logic [QUO_W-1:0] quo;
  } prvm_lane_t;

endpackage

/* rtl/prvm_ifs.sv */
interface prvm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [prvm_pkg::OP_W-1:0]             opcode;
  logic signed [prvm_pkg::COORD_W-1:0]   in_x;
  logic signed [prvm_pkg::COORD_W-1:0]   in_y;
  logic signed [prvm_pkg::ANGLE_W-1:0]   angle;
  modport source (output valid, opcode, in_x, in_y, angle, input ready);
  modport sink (input valid, opcode, in_x, in_y, angle, output ready);
endinterface

interface prvm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [prvm_pkg::COORD_W-1:0]   out_x;
  logic signed [prvm_pkg::COORD_W-1:0]   out_y;
  logic                                  overflow;
  modport source (output valid, out_x, out_y, overflow, input ready);
  modport sink (input valid, out_x, out_y, overflow, output ready);
endinterface

interface prvm_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [prvm_pkg::CFG_IDX_W-1:0]        reg_index;
  logic [prvm_pkg::CFG_DATA_W-1:0]       data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

/* rtl/prvm_udiv.sv */
// Pipelined signed-by-unsigned divider, two lanes, one quotient bit per stage after stage 0.
// Stage 0 takes magnitudes and flags quotients of 2^17 or more.
module prvm_udiv (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [33:0]      num_x,
  input  logic signed [33:0]      num_y,
  input  logic [15:0]             dvs_x,
  input  logic [15:0]             dvs_y,
  input  prvm_pkg::prvm_side_t    side_in,
  output logic                    out_vld,
  output prvm_pkg::prvm_lane_t    lane_x,
  output prvm_pkg::prvm_lane_t    lane_y,
  output prvm_pkg::prvm_side_t    side_out
);

  localparam int Steps = prvm_pkg::QUO_W;

  logic                 vld_r  [0:Steps];
  prvm_pkg::prvm_lane_t lx_r   [0:Steps];
  prvm_pkg::prvm_lane_t ly_r   [0:Steps];
  prvm_pkg::prvm_side_t side_r [0:Steps];

  function automatic prvm_pkg::prvm_lane_t lane_init(logic signed [33:0] n, logic [15:0] d);
    prvm_pkg::prvm_lane_t l;
    logic [33:0]          m;
    m     = n[33] ? 34'(-n) : n;
    l.neg = n[33];
    l.dvs = d;
    l.rem = m[31:0];
    l.big = (m[32:0] >= {d, 17'b0});
    l.quo = '0;
    return l;
  endfunction

  // restoring step: try divisor shifted to bit sh
  function automatic prvm_pkg::prvm_lane_t lane_step(prvm_pkg::prvm_lane_t l, int unsigned sh);
    prvm_pkg::prvm_lane_t o;
    logic [32:0]          dsh;
    logic [32:0]          r;
    o   = l;
    dsh = {17'b0, l.dvs} << sh;
    r   = {1'b0, l.rem};
    if (r >= dsh) begin
      o.rem = 32'(r - dsh);
      o.quo = l.quo | (17'd1 << sh);
    end
    return o;
  endfunction

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx_r[0]   <= lane_init(num_x, dvs_x);
      ly_r[0]   <= lane_init(num_y, dvs_y);
      side_r[0] <= side_in;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 1; k <= Steps; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lx_r[k]   <= lane_step(lx_r[k-1], Steps - k);
        ly_r[k]   <= lane_step(ly_r[k-1], Steps - k);
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[Steps];
  assign lane_x   = lx_r[Steps];
  assign lane_y   = ly_r[Steps];
  assign side_out = side_r[Steps];

endmodule

/* rtl/point_rotate_and_viewport_map_unit.sv */
// Channel  | Dir | Carries
// ---------+-----+-----------------------------------------------
// in_ch    | in  | opcode, in_x, in_y, angle
// out_ch   | out | out_x, out_y, overflow
// cfg_ch   | in  | reg_index, data (always ready)
//
// One item per cycle while the skid entry is empty; each transfer passes stages A, B, C,
// the 18-stage divider used by unmap, stages D to M and the output register.
// rst_n is synchronous: it clears valid bits and the registers to their defaults.
// A two-entry output (register plus skid) stalls the whole pipeline only when full;
// in_ch.ready comes from a register, never from out_ch.ready.
module point_rotate_and_viewport_map_unit (
  input  logic       clk,
  input  logic       rst_n,
  prvm_in_if.sink    in_ch,
  prvm_out_if.source out_ch,
  prvm_cfg_if.sink   cfg_ch
);

  localparam int RW = prvm_pkg::ROT_W;
  localparam int CW = prvm_pkg::COORD_W;

  typedef struct packed {
    logic [prvm_pkg::OP_W-1:0] op;
    logic signed [CW-1:0]      x;
    logic signed [CW-1:0]      y;
    logic                      ovf;
  } pt_t;

  // -------- helpers --------
  function automatic logic [16:0] sat16(logic signed [19:0] v);
    logic [16:0] r;
    if (v > 20'sd32767) begin
      r = {1'b1, 16'h7FFF};
    end else if (v < -20'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  // a / 32767 for a < 2^31, using 32767 = 2^15 - 1
  function automatic logic [16:0] div32767(logic [30:0] a);
    logic [15:0] q0;
    logic [16:0] r1;
    logic [1:0]  q1;
    logic [15:0] r2;
    q0 = a[30:15];
    r1 = {2'b0, a[14:0]} + {1'b0, q0};
    q1 = r1[16:15];
    r2 = {1'b0, r1[14:0]} + {14'b0, q1};
    return {1'b0, q0} + {15'b0, q1} + {16'b0, (r2 >= 16'd32767)};
  endfunction

  // {cos, sin} for a table step
  function automatic logic [31:0] trig(logic [RW-1:0] idx);
    logic [15:0] sj;
    logic [15:0] cj;
    logic [31:0] r;
    sj = prvm_pkg::QSIN[{1'b0, idx[RW-3:0]}];
    cj = prvm_pkg::QSIN[8'd128 - {1'b0, idx[RW-3:0]}];
    case (idx[RW-1:RW-2])
      2'd0:    r = {cj, sj};
      2'd1:    r = {16'(-sj), cj};
      2'd2:    r = {16'(-cj), 16'(-sj)};
      default: r = {sj, 16'(-cj)};
    endcase
    return r;
  endfunction

  // unmap tail: signed quotient minus 32767
  function automatic logic signed [19:0] unmap_fin(prvm_pkg::prvm_lane_t l);
    logic [17:0]        q;
    logic signed [19:0] t;
    q = l.big ? 18'h20000 : {1'b0, l.quo};
    t = l.neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
    return t - 20'sd32767;
  endfunction

  // -------- configuration registers --------
  logic [RW-1:0]        rot_cfg_r;
  logic signed [CW-1:0] org_x_r;
  logic signed [CW-1:0] org_y_r;
  logic [CW-1:0]        size_x_r;
  logic [CW-1:0]        size_y_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cfg_r <= '0;
      org_x_r   <= '0;
      org_y_r   <= '0;
      size_x_r  <= 16'd1;
      size_y_r  <= 16'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        prvm_pkg::REG_MAP_ROTATION:  rot_cfg_r <= cfg_ch.data[RW-1:0];
        prvm_pkg::REG_REGION_LEFT:   org_x_r   <= cfg_ch.data;
        prvm_pkg::REG_REGION_TOP:    org_y_r   <= cfg_ch.data;
        prvm_pkg::REG_REGION_WIDTH:  size_x_r  <= cfg_ch.data;
        prvm_pkg::REG_REGION_HEIGHT: size_y_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // -------- pipeline control --------
  logic en;
  logic skid_vld_r;
  assign en          = !skid_vld_r;
  assign in_ch.ready = en;

  logic [2:0] front_vld_r;  // stages A, B, C
  logic [9:0] tail_vld_r;   // stages D .. M
  logic       div_vld;

  // -------- stage A: capture, pick rotation step --------
  logic [RW-1:0]      a_rot_nxt;
  prvm_pkg::prvm_side_t a_r;

  always_comb begin
    case (in_ch.opcode)
      prvm_pkg::OP_MAP:    a_rot_nxt = rot_cfg_r;
      prvm_pkg::OP_UNMAP:  a_rot_nxt = RW'(0) - rot_cfg_r;
      prvm_pkg::OP_ROTATE: a_rot_nxt = in_ch.angle[RW-1:0];
      default:             a_rot_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= '0;
    end else if (en) begin
      front_vld_r <= {front_vld_r[1:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r.op  <= in_ch.opcode;
      a_r.x   <= in_ch.in_x;
      a_r.y   <= in_ch.in_y;
      a_r.rot <= a_rot_nxt;
    end
  end

  // -------- stage B: offset from region origin --------
  prvm_pkg::prvm_side_t b_r;
  logic signed [16:0]   b_dx_r;
  logic signed [16:0]   b_dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_r    <= a_r;
      b_dx_r <= $signed({a_r.x[15], a_r.x}) - $signed({org_x_r[15], org_x_r});
      b_dy_r <= $signed({a_r.y[15], a_r.y}) - $signed({org_y_r[15], org_y_r});
    end
  end

  // -------- stage C: numerator d*65534 + size/2 --------
  prvm_pkg::prvm_side_t c_r;
  logic signed [33:0]   c_nx_r;
  logic signed [33:0]   c_ny_r;
  logic signed [33:0]   b_dx34;
  logic signed [33:0]   b_dy34;

  assign b_dx34 = {{17{b_dx_r[16]}}, b_dx_r};
  assign b_dy34 = {{17{b_dy_r[16]}}, b_dy_r};

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= b_r;
      c_nx_r <= (b_dx34 <<< 16) - (b_dx34 <<< 1) + $signed({19'b0, size_x_r[15:1]});
      c_ny_r <= (b_dy34 <<< 16) - (b_dy34 <<< 1) + $signed({19'b0, size_y_r[15:1]});
    end
  end

  // -------- divider: stages 0..17 --------
  logic [15:0]          dvs_x;
  logic [15:0]          dvs_y;
  prvm_pkg::prvm_lane_t div_lx;
  prvm_pkg::prvm_lane_t div_ly;
  prvm_pkg::prvm_side_t div_side;

  // a zero size divides as one
  assign dvs_x = (size_x_r == '0) ? 16'd1 : size_x_r;
  assign dvs_y = (size_y_r == '0) ? 16'd1 : size_y_r;

  prvm_udiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (front_vld_r[2]),
    .num_x    (c_nx_r),
    .num_y    (c_ny_r),
    .dvs_x    (dvs_x),
    .dvs_y    (dvs_y),
    .side_in  (c_r),
    .out_vld  (div_vld),
    .lane_x   (div_lx),
    .lane_y   (div_ly),
    .side_out (div_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_vld_r <= '0;
    end else if (en) begin
      tail_vld_r <= {tail_vld_r[8:0], div_vld};
    end
  end

  // -------- stage D: unmap result, trig lookup --------
  pt_t                  d_p_r;
  logic signed [15:0]   d_c_r;
  logic signed [15:0]   d_s_r;
  logic                 d_do_r;
  logic [16:0]          d_ux;
  logic [16:0]          d_uy;
  logic                 d_unmap;

  assign d_ux    = sat16(unmap_fin(div_lx));
  assign d_uy    = sat16(unmap_fin(div_ly));
  assign d_unmap = (div_side.op == prvm_pkg::OP_UNMAP);

  always_ff @(posedge clk) begin
    if (en) begin
      d_p_r.op       <= div_side.op;
      d_p_r.x        <= d_unmap ? d_ux[15:0] : div_side.x;
      d_p_r.y        <= d_unmap ? d_uy[15:0] : div_side.y;
      d_p_r.ovf      <= d_unmap & (d_ux[16] | d_uy[16]);
      {d_c_r, d_s_r} <= trig(div_side.rot);
      d_do_r         <= (div_side.rot != '0);
    end
  end

  // -------- stage E: four products --------
  pt_t                e_p_r;
  logic               e_do_r;
  logic signed [31:0] e_xc_r;
  logic signed [31:0] e_ys_r;
  logic signed [31:0] e_xs_r;
  logic signed [31:0] e_yc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_p_r  <= d_p_r;
      e_do_r <= d_do_r;
      e_xc_r <= d_p_r.x * d_c_r;
      e_ys_r <= d_p_r.y * d_s_r;
      e_xs_r <= d_p_r.x * d_s_r;
      e_yc_r <= d_p_r.y * d_c_r;
    end
  end

  // -------- stage F: sums, magnitude plus half --------
  pt_t                f_p_r;
  logic               f_do_r;
  logic               f_nx_r;
  logic               f_ny_r;
  logic [30:0]        f_mx_r;
  logic [30:0]        f_my_r;
  logic signed [32:0] e_tx;
  logic signed [32:0] e_ty;

  assign e_tx = $signed({e_xc_r[31], e_xc_r}) - $signed({e_ys_r[31], e_ys_r});
  assign e_ty = $signed({e_xs_r[31], e_xs_r}) + $signed({e_yc_r[31], e_yc_r});

  always_ff @(posedge clk) begin
    if (en) begin
      f_p_r  <= e_p_r;
      f_do_r <= e_do_r;
      f_nx_r <= e_tx[32];
      f_ny_r <= e_ty[32];
      f_mx_r <= e_tx[32] ? 31'(33'sd16383 - e_tx) : 31'(e_tx + 33'sd16383);
      f_my_r <= e_ty[32] ? 31'(33'sd16383 - e_ty) : 31'(e_ty + 33'sd16383);
    end
  end

  // -------- stage G: divide by 32767 --------
  pt_t         g_p_r;
  logic        g_do_r;
  logic        g_nx_r;
  logic        g_ny_r;
  logic [16:0] g_qx_r;
  logic [16:0] g_qy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g_p_r  <= f_p_r;
      g_do_r <= f_do_r;
      g_nx_r <= f_nx_r;
      g_ny_r <= f_ny_r;
      g_qx_r <= div32767(f_mx_r);
      g_qy_r <= div32767(f_my_r);
    end
  end

  // -------- stage H: sign, saturate, bypass on zero rotation --------
  pt_t                h_p_r;
  logic signed [19:0] g_vx;
  logic signed [19:0] g_vy;
  logic [16:0]        g_sx;
  logic [16:0]        g_sy;

  assign g_vx = g_nx_r ? -$signed({3'b0, g_qx_r}) : $signed({3'b0, g_qx_r});
  assign g_vy = g_ny_r ? -$signed({3'b0, g_qy_r}) : $signed({3'b0, g_qy_r});
  assign g_sx = sat16(g_vx);
  assign g_sy = sat16(g_vy);

  always_ff @(posedge clk) begin
    if (en) begin
      h_p_r.op  <= g_p_r.op;
      h_p_r.x   <= g_do_r ? g_sx[15:0] : g_p_r.x;
      h_p_r.y   <= g_do_r ? g_sy[15:0] : g_p_r.y;
      h_p_r.ovf <= g_p_r.ovf | (g_do_r & (g_sx[16] | g_sy[16]));
    end
  end

  // -------- stage I: shift into -1..65534 --------
  pt_t                i_p_r;
  logic signed [17:0] i_sx_r;
  logic signed [17:0] i_sy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      i_p_r  <= h_p_r;
      i_sx_r <= $signed({{2{h_p_r.x[15]}}, h_p_r.x}) + 18'sd32767;
      i_sy_r <= $signed({{2{h_p_r.y[15]}}, h_p_r.y}) + 18'sd32767;
    end
  end

  // -------- stage J: times region size --------
  pt_t                j_p_r;
  logic signed [34:0] j_px_r;
  logic signed [34:0] j_py_r;

  always_ff @(posedge clk) begin
    if (en) begin
      j_p_r  <= i_p_r;
      j_px_r <= i_sx_r * $signed({1'b0, size_x_r});
      j_py_r <= i_sy_r * $signed({1'b0, size_y_r});
    end
  end

  // -------- stage K: add half span, halve; non-positive gives zero --------
  pt_t                k_p_r;
  logic [30:0]        k_hx_r;
  logic [30:0]        k_hy_r;
  logic signed [35:0] j_nx;
  logic signed [35:0] j_ny;

  assign j_nx = $signed({j_px_r[34], j_px_r}) + 36'sd32767;
  assign j_ny = $signed({j_py_r[34], j_py_r}) + 36'sd32767;

  always_ff @(posedge clk) begin
    if (en) begin
      k_p_r  <= j_p_r;
      k_hx_r <= j_nx[35] ? '0 : j_nx[31:1];
      k_hy_r <= j_ny[35] ? '0 : j_ny[31:1];
    end
  end

  // -------- stage L: divide by 32767 (span 65534 after halving) --------
  pt_t         l_p_r;
  logic [16:0] l_tx_r;
  logic [16:0] l_ty_r;

  always_ff @(posedge clk) begin
    if (en) begin
      l_p_r  <= k_p_r;
      l_tx_r <= div32767(k_hx_r);
      l_ty_r <= div32767(k_hy_r);
    end
  end

  // -------- stage M: add origin, saturate, final select --------
  pt_t                m_p_r;
  logic signed [19:0] l_ox;
  logic signed [19:0] l_oy;
  logic [16:0]        l_sx;
  logic [16:0]        l_sy;
  logic               l_map;

  assign l_ox  = $signed({{4{org_x_r[15]}}, org_x_r}) + $signed({3'b0, l_tx_r});
  assign l_oy  = $signed({{4{org_y_r[15]}}, org_y_r}) + $signed({3'b0, l_ty_r});
  assign l_sx  = sat16(l_ox);
  assign l_sy  = sat16(l_oy);
  assign l_map = (l_p_r.op == prvm_pkg::OP_MAP);

  always_ff @(posedge clk) begin
    if (en) begin
      m_p_r.op  <= l_p_r.op;
      m_p_r.x   <= l_map ? l_sx[15:0] : l_p_r.x;
      m_p_r.y   <= l_map ? l_sy[15:0] : l_p_r.y;
      m_p_r.ovf <= l_p_r.ovf | (l_map & (l_sx[16] | l_sy[16]));
    end
  end

  // -------- output register and skid entry --------
  logic                 out_vld_r;
  logic signed [CW-1:0] out_x_r;
  logic signed [CW-1:0] out_y_r;
  logic                 out_ovf_r;
  pt_t                  skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ch.ready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= tail_vld_r[9];
      end
    end else if (tail_vld_r[9] && en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ch.ready) begin
      out_x_r   <= skid_vld_r ? skid_r.x : m_p_r.x;
      out_y_r   <= skid_vld_r ? skid_r.y : m_p_r.y;
      out_ovf_r <= skid_vld_r ? skid_r.ovf : m_p_r.ovf;
    end else if (en) begin
      skid_r <= m_p_r;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.out_x    = out_x_r;
  assign out_ch.out_y    = out_y_r;
  assign out_ch.overflow = out_ovf_r;

endmodule

/* rtl/prvm_chk.sv */
`include "assert_macros.svh"

// Port-level checks on the point unit.
module prvm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic        out_overflow
);

  // nothing pending and input open right after reset
  `AST_RST(a_rst_out_idle, !out_valid)
  `AST_RST(a_rst_in_open, in_ready)

  // input closes only after the output stalled a result
  `AST_IMPL(a_in_block_cause, !in_ready, $past(out_valid && !out_ready))

  // a stalled result holds
  `AST_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_x) && $stable(out_y) && $stable(out_overflow))

endmodule

bind point_rotate_and_viewport_map_unit prvm_chk u_prvm_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_x        (out_ch.out_x),
  .out_y        (out_ch.out_y),
  .out_overflow (out_ch.overflow)
);

/* dv/tb_point_rotate_and_viewport_map_unit.sv */
module tb_point_rotate_and_viewport_map_unit;

  // opcode with no operation: the point passes through
  localparam logic [prvm_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  // one predicted output point
  typedef struct {
    logic signed [prvm_pkg::COORD_W-1:0] px;
    logic signed [prvm_pkg::COORD_W-1:0] py;
    logic                                ovf;
  } point_t;

  // holds the register copy, predicts each transfer and checks results in order
  class point_scoreboard;
    logic [prvm_pkg::ROT_W-1:0] rot_q;
    logic signed [15:0]         left_q;
    logic signed [15:0]         top_q;
    logic [15:0]                width_q;
    logic [15:0]                height_q;
    point_t                     pending_q[$];
    int                         errors;
    int                         checked;
    int                         ovf_seen;

    function new();
      rot_q = '0; left_q = '0; top_q = '0; width_q = 16'd1; height_q = 16'd1;
      errors = 0; checked = 0; ovf_seen = 0;
    endfunction

    function void write_reg(logic [prvm_pkg::CFG_IDX_W-1:0] idx,
                            logic [prvm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        prvm_pkg::REG_MAP_ROTATION:  rot_q = data[prvm_pkg::ROT_W-1:0];
        prvm_pkg::REG_REGION_LEFT:   left_q = data;
        prvm_pkg::REG_REGION_TOP:    top_q = data;
        prvm_pkg::REG_REGION_WIDTH:  width_q = data;
        prvm_pkg::REG_REGION_HEIGHT: height_q = data;
        default: ;
      endcase
    endfunction

    function automatic longint clamp16(longint v, inout bit ovf);
      if (v > 32767) begin ovf = 1; return 32767; end
      if (v < -32768) begin ovf = 1; return -32768; end
      return v;
    endfunction

    // Q15 product sum, rounded half away from zero
    function automatic longint q15_div(longint t);
      longint bias;
      bias = (t > 0) ? 16383 : ((t < 0) ? -16383 : 0);
      return (t + bias) / 32767;
    endfunction

    function automatic void turn(inout longint x, inout longint y,
                                 input logic [prvm_pkg::ROT_W-1:0] step, inout bit ovf);
      longint c, s, sj, cj, nx, ny;
      int j;
      if (step == 0) return;
      j = step % 128;
      sj = prvm_pkg::QSIN[j];
      cj = prvm_pkg::QSIN[128-j];
      case (step / 128)
        0: begin c = cj;  s = sj;  end
        1: begin c = -sj; s = cj;  end
        2: begin c = -cj; s = -sj; end
        default: begin c = sj; s = -cj; end
      endcase
      nx = clamp16(q15_div(x * c - y * s), ovf);
      ny = clamp16(q15_div(x * s + y * c), ovf);
      x = nx;
      y = ny;
    endfunction

    function automatic longint to_pixel(longint v, longint origin, longint size,
                                        inout bit ovf);
      return clamp16(origin + ((v + 32767) * size + 32767) / 65534, ovf);
    endfunction

    function automatic longint to_vector(longint v, longint origin, longint size,
                                         inout bit ovf);
      longint d;
      d = (size == 0) ? 1 : size;
      return clamp16((((v - origin) * 65534 + d / 2) / d) - 32767, ovf);
    endfunction

    function void note_input(logic [prvm_pkg::OP_W-1:0] op, logic signed [15:0] ix,
                             logic signed [15:0] iy,
                             logic signed [prvm_pkg::ANGLE_W-1:0] ang);
      longint x, y;
      bit ovf;
      point_t p;
      x = ix; y = iy; ovf = 0;
      case (op)
        prvm_pkg::OP_MAP: begin
          turn(x, y, rot_q, ovf);
          x = to_pixel(x, left_q, width_q, ovf);
          y = to_pixel(y, top_q, height_q, ovf);
        end
        prvm_pkg::OP_UNMAP: begin
          x = to_vector(x, left_q, width_q, ovf);
          y = to_vector(y, top_q, height_q, ovf);
          turn(x, y, prvm_pkg::ROT_W'(prvm_pkg::TRIG_STEPS - rot_q), ovf);
        end
        prvm_pkg::OP_ROTATE: turn(x, y, ang[prvm_pkg::ROT_W-1:0], ovf);
        default: ;
      endcase
      p.px = x[15:0]; p.py = y[15:0]; p.ovf = ovf;
      pending_q.push_back(p);
    endfunction

    function void check(logic signed [15:0] ox, logic signed [15:0] oy, logic of);
      point_t p;
      if (pending_q.size() == 0) begin
        $error("result transfer with no prediction pending");
        errors++;
        return;
      end
      p = pending_q.pop_front();
      checked++;
      if (of) ovf_seen++;
      if (ox !== p.px) begin
        $error("out_x expected %0d actual %0d", p.px, ox); errors++;
      end
      if (oy !== p.py) begin
        $error("out_y expected %0d actual %0d", p.py, oy); errors++;
      end
      if (of !== p.ovf) begin
        $error("overflow expected %0d actual %0d", p.ovf, of); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  prvm_in_if  in_ch();
  prvm_out_if out_ch();
  prvm_cfg_if cfg_ch();

  point_rotate_and_viewport_map_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  point_scoreboard sb = new();
  int src_idle_pct;
  int dst_stall_pct;
  int items_sent;
  int cfg_writes;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // transfer monitors, sampled at the edge before any update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.opcode, in_ch.in_x, in_ch.in_y, in_ch.angle);
      if (out_ch.valid && out_ch.ready)
        sb.check(out_ch.out_x, out_ch.out_y, out_ch.overflow);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(cfg_ch.reg_index, cfg_ch.data);
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= dst_stall_pct);
  end

  task automatic send_point(logic [prvm_pkg::OP_W-1:0] op, logic signed [15:0] x,
                            logic signed [15:0] y,
                            logic signed [prvm_pkg::ANGLE_W-1:0] ang);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.in_x   <= x;
    in_ch.in_y   <= y;
    in_ch.angle  <= ang;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // stop sending until every prediction is matched, then let the pipe empty;
  // the last input transfer is noted by the monitor before the queue is polled
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [prvm_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic set_region(logic [prvm_pkg::ROT_W-1:0] rot, logic [15:0] l,
                            logic [15:0] t, logic [15:0] w, logic [15:0] h);
    write_reg(prvm_pkg::REG_MAP_ROTATION, 16'(rot));
    write_reg(prvm_pkg::REG_REGION_LEFT, l);
    write_reg(prvm_pkg::REG_REGION_TOP, t);
    write_reg(prvm_pkg::REG_REGION_WIDTH, w);
    write_reg(prvm_pkg::REG_REGION_HEIGHT, h);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(16'($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(6))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hffff;
      3: return 16'($urandom_range(2000, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [prvm_pkg::ROT_W-1:0] pick_rot();
    case ($urandom_range(5))
      0: return 9'd0;
      1: return 9'd511;
      2: return 9'(128 * $urandom_range(3));
      default: return 9'($urandom);
    endcase
  endfunction

  // random points; unmap points mostly land inside the region
  task automatic random_points(int n);
    logic [prvm_pkg::OP_W-1:0] op;
    logic [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(19) == 0) ? OP_SPARE : prvm_pkg::OP_W'($urandom_range(2));
      x = pick_coord();
      y = pick_coord();
      if (op == prvm_pkg::OP_UNMAP && $urandom_range(3) != 0) begin
        x = sb.left_q + 16'($urandom_range(sb.width_q));
        y = sb.top_q + 16'($urandom_range(sb.height_q));
      end
      send_point(op, x, y, prvm_pkg::ANGLE_W'($urandom));
    end
  endtask

  initial begin
    int modes_src[4] = '{0, 67, 0, 23};
    int modes_dst[4] = '{0, 0, 67, 23};
    rst_n = 1'b0;
    src_idle_pct = 0; dst_stall_pct = 0; items_sent = 0; cfg_writes = 0;
    in_ch.valid <= 1'b0; in_ch.opcode <= '0; in_ch.in_x <= '0;
    in_ch.in_y <= '0; in_ch.angle <= '0;
    cfg_ch.valid <= 1'b0; cfg_ch.reg_index <= '0; cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset region, a real viewport, then a region of zero width
    send_point(prvm_pkg::OP_MAP, 16'h7fff, 16'h8000, '0);
    send_point(prvm_pkg::OP_UNMAP, 16'h0000, 16'h0001, '0);
    send_point(prvm_pkg::OP_UNMAP, 16'h7fff, 16'h8000, '0);
    send_point(prvm_pkg::OP_ROTATE, 16'h7fff, 16'h7fff, 10'sd64);
    send_point(prvm_pkg::OP_ROTATE, 16'h8000, 16'h8000, -10'sd512);
    send_point(prvm_pkg::OP_ROTATE, 16'h1234, 16'hf00d, -10'sd1);
    send_point(prvm_pkg::OP_ROTATE, 16'h1234, 16'hf00d, 10'sd511);
    send_point(prvm_pkg::OP_ROTATE, 16'h1234, 16'hf00d, 10'sd0);
    send_point(prvm_pkg::OP_ROTATE, 16'h8000, 16'h7fff, 10'sd128);
    send_point(prvm_pkg::OP_ROTATE, 16'h8000, 16'h7fff, 10'sd256);
    send_point(OP_SPARE, 16'h8000, 16'h7fff, 10'sd5);
    drain();
    set_region(9'd64, -16'sd100, 16'sd50, 16'd640, 16'd480);
    send_point(prvm_pkg::OP_MAP, 16'h8000, 16'h8000, '0);
    send_point(prvm_pkg::OP_MAP, 16'h7fff, 16'h7fff, '0);
    send_point(prvm_pkg::OP_MAP, 16'h0000, 16'h0000, '0);
    send_point(prvm_pkg::OP_UNMAP, -16'sd100, 16'sd50, '0);
    send_point(prvm_pkg::OP_UNMAP, 16'sd540, 16'sd530, '0);
    send_point(prvm_pkg::OP_UNMAP, 16'h7fff, 16'h8000, '0);
    drain();
    set_region(9'd511, 16'h7fff, 16'h8000, 16'd0, 16'hffff);
    send_point(prvm_pkg::OP_MAP, 16'h7fff, 16'h8000, '0);
    send_point(prvm_pkg::OP_UNMAP, 16'h7fff, 16'h8000, '0);
    send_point(prvm_pkg::OP_UNMAP, 16'h0000, 16'h0000, '0);
    send_point(prvm_pkg::OP_MAP, 16'h0000, 16'h0000, '0);
    drain();

    // random phases, region changed between them, idling pattern rotating
    for (int ph = 0; ph < 12; ph++) begin
      src_idle_pct  = modes_src[ph % 4];
      dst_stall_pct = modes_dst[ph % 4];
      if (ph == 11) set_region(9'd0, 16'h8000, 16'h7fff, 16'hffff, 16'd1);
      else set_region(pick_rot(), pick_coord(), pick_coord(), pick_size(), pick_size());
      random_points(70);
      drain();
      random_points(70);
      drain();
    end

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      $error("%0d predicted results never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("covered %0d points and %0d register writes; %0d results checked, %0d saturated",
             items_sent, cfg_writes, sb.checked, sb.ovf_seen);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/prvm_pkg.sv
rtl/prvm_ifs.sv
rtl/prvm_udiv.sv
rtl/point_rotate_and_viewport_map_unit.sv
rtl/prvm_chk.sv
dv/tb_point_rotate_and_viewport_map_unit.sv
